[design/qtpl_pkg.sv]
// shared constants, widths and types of the quantized track path length block
// used by qtpl_scale and quantized_track_path_length; depends on nothing
package qtpl_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int SLOT_W      = $clog2(MAX_RECORDS + 1);

  localparam int COORD_W = 16;
  localparam int EXT_W   = 32;
  localparam int SUM_W   = 32;
  localparam int OUT_W   = 40;
  localparam int RAD_W   = 35;
  localparam int ROOT_W  = 17;

  // scaling by extent / (256 * 32767), rounded half up
  localparam int PROD_W      = 2 * EXT_W;
  localparam int SCALE_SHIFT = 8;
  localparam int DIV_W       = PROD_W - SCALE_SHIFT;
  localparam int REM_W       = 16;
  localparam logic [PROD_W-1:0] SCALE_HALF    = PROD_W'(64'd4194176);
  localparam logic [REM_W-1:0]  SCALE_DIVISOR = REM_W'(16'd32767);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_EXTENT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIME_EXTENT = CFG_IDX_W'(1);

  localparam logic [EXT_W-1:0] EXTENT_RESET = EXT_W'(32'd65536);

  typedef struct packed {
    logic busy;
    logic done;
  } scale_stat_t;

endpackage

[design/quantized_track_path_length.sv]
// top level of the quantized track path length block: record sequencer and root unit
// depends on qtpl_pkg and qtpl_scale
//
// Takes one photon's step records and, at its final slot, gives path length, first-to-last
// distance and duration. A record is taken only while the sequencer is idle. An unset
// record or the first set record of a photon goes straight to the slot check; every later
// set record first passes the squared-difference sum over three coordinates and the
// 18-step bit-serial square root of a 35-bit radicand. The final slot adds the end-distance
// root, three passes through the serial scaling unit (shift-add multiply, a rounding step,
// restoring divide by 32767, start and done hand-off) and the output state; a photon
// without any set record skips the root and the scaling and gives zeros. The result sits
// in an output register, so the next record is taken while it waits; a new result waits
// only if the previous one is still not taken. Configuration writes are taken in every
// cycle.
module quantized_track_path_length (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [63:0]                        in_tdata,   // pos_x, pos_y, pos_z, time_code
  input  logic                               in_tuser,   // record_unset
  input  logic                               in_tlast,   // last_record
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [119:0]                       out_tdata,  // path_length, end_distance,
                                                         // path_duration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qtpl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qtpl_pkg::EXT_W-1:0]         cfg_data
);

  localparam int CW = qtpl_pkg::COORD_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SQ      = 3'd1;
  localparam logic [2:0] ST_ROOT    = 3'd2;
  localparam logic [2:0] ST_CHK     = 3'd3;
  localparam logic [2:0] ST_SC_GO   = 3'd4;
  localparam logic [2:0] ST_SC_WAIT = 3'd5;
  localparam logic [2:0] ST_OUT     = 3'd6;

  localparam logic [1:0] SEL_LEN = 2'd0;
  localparam logic [1:0] SEL_END = 2'd1;
  localparam logic [1:0] SEL_DUR = 2'd2;

  localparam logic [qtpl_pkg::RAD_W-1:0] ROOT_BIT_INIT =
    qtpl_pkg::RAD_W'(1) << (qtpl_pkg::RAD_W - 1);

  logic [2:0]                          state_r;
  logic [qtpl_pkg::EXT_W-1:0]          pos_ext_r;
  logic [qtpl_pkg::EXT_W-1:0]          time_ext_r;

  logic signed [CW-1:0]                cur_r   [3];
  logic signed [CW-1:0]                prev_r  [3];
  logic signed [CW-1:0]                first_r [3];
  logic signed [CW-1:0]                cur_t_r;
  logic signed [CW-1:0]                first_t_r;
  logic signed [CW-1:0]                last_t_r;

  logic                                end_r;
  logic                                have_r;
  logic                                end_mode_r;
  logic [qtpl_pkg::SLOT_W-1:0]         slot_r;
  logic [qtpl_pkg::SUM_W-1:0]          len_sum_r;
  logic [1:0]                          sq_idx_r;
  logic [qtpl_pkg::RAD_W-1:0]          num_r;
  logic [qtpl_pkg::RAD_W-1:0]          res_r;
  logic [qtpl_pkg::RAD_W-1:0]          bit_r;
  logic [qtpl_pkg::ROOT_W-1:0]         root_r;
  logic [1:0]                          sel_r;
  logic [qtpl_pkg::OUT_W-1:0]          len_q_r;
  logic [qtpl_pkg::OUT_W-1:0]          end_q_r;
  logic [qtpl_pkg::OUT_W-1:0]          dur_q_r;
  logic                                out_tvalid_r;
  logic [119:0]                        out_data_r;

  logic                                in_xfer;
  logic [qtpl_pkg::SLOT_W-1:0]         slot_nxt;
  logic signed [CW-1:0]                op_a;
  logic signed [CW-1:0]                op_b;
  logic [CW:0]                         diff;
  logic [CW:0]                         diff_mag;
  logic [2*CW-1:0]                     sq_val;
  logic [qtpl_pkg::RAD_W-1:0]          trial;
  logic                                take;
  logic [qtpl_pkg::RAD_W-1:0]          num_nxt;
  logic [qtpl_pkg::RAD_W-1:0]          res_nxt;
  logic [qtpl_pkg::SUM_W:0]            len_acc;
  logic [CW:0]                         dt;
  logic                                dt_neg;
  logic [CW:0]                         dt_mag;
  logic                                sc_start;
  logic [qtpl_pkg::EXT_W-1:0]          sc_s;
  logic [qtpl_pkg::EXT_W-1:0]          sc_e;
  qtpl_pkg::scale_stat_t               sc_stat;
  logic [qtpl_pkg::OUT_W-1:0]          sc_quot;
  logic                                out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign slot_nxt  = slot_r + 1'b1;

  // squared difference of one coordinate, a step or the first-to-last span
  always_comb begin
    op_a     = end_mode_r ? prev_r[sq_idx_r]  : cur_r[sq_idx_r];
    op_b     = end_mode_r ? first_r[sq_idx_r] : prev_r[sq_idx_r];
    diff     = {op_a[CW-1], op_a} - {op_b[CW-1], op_b};
    diff_mag = diff[CW] ? ((CW+1)'(0) - diff) : diff;
    sq_val   = diff_mag[CW-1:0] * diff_mag[CW-1:0];
  end

  // one result bit of the square root per cycle
  always_comb begin
    trial   = res_r + bit_r;
    take    = (num_r >= trial);
    num_nxt = take ? (num_r - trial) : num_r;
    res_nxt = take ? ((res_r >> 1) + bit_r) : (res_r >> 1);
    len_acc = {1'b0, len_sum_r} + (qtpl_pkg::SUM_W+1)'(res_nxt[qtpl_pkg::ROOT_W-1:0]);
  end

  always_comb begin
    dt     = {last_t_r[CW-1], last_t_r} - {first_t_r[CW-1], first_t_r};
    dt_neg = dt[CW];
    dt_mag = dt_neg ? ((CW+1)'(0) - dt) : dt;
  end

  always_comb begin
    sc_start = (state_r == ST_SC_GO);
    case (sel_r)
      SEL_LEN: begin
        sc_s = len_sum_r;
        sc_e = pos_ext_r;
      end
      SEL_END: begin
        sc_s = qtpl_pkg::EXT_W'(root_r);
        sc_e = pos_ext_r;
      end
      default: begin
        sc_s = qtpl_pkg::EXT_W'(dt_mag);
        sc_e = time_ext_r;
      end
    endcase
  end

  assign out_load = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  qtpl_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sc_start),
    .mult_s (sc_s),
    .mult_e (sc_e),
    .stat   (sc_stat),
    .quot   (sc_quot)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_ext_r    <= qtpl_pkg::EXTENT_RESET;
      time_ext_r   <= qtpl_pkg::EXTENT_RESET;
      have_r       <= 1'b0;
      len_sum_r    <= '0;
      slot_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          qtpl_pkg::REG_POS_EXTENT:  pos_ext_r  <= cfg_data;
          qtpl_pkg::REG_TIME_EXTENT: time_ext_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            slot_r <= slot_nxt;
            if (!in_tuser && have_r) begin
              state_r <= ST_SQ;
            end else begin
              if (!in_tuser) begin
                have_r <= 1'b1;
              end
              state_r <= ST_CHK;
            end
          end
        end
        ST_SQ: begin
          if (sq_idx_r == 2'd2) begin
            state_r <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (bit_r[0]) begin
            if (end_mode_r) begin
              state_r <= ST_SC_GO;
            end else begin
              len_sum_r <= len_acc[qtpl_pkg::SUM_W] ? '1 : len_acc[qtpl_pkg::SUM_W-1:0];
              state_r   <= ST_CHK;
            end
          end
        end
        ST_CHK: begin
          if (!end_r) begin
            state_r <= ST_IDLE;
          end else if (have_r) begin
            state_r <= ST_SQ;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_SC_GO: state_r <= ST_SC_WAIT;
        ST_SC_WAIT: begin
          if (sc_stat.done) begin
            state_r <= (sel_r == SEL_DUR) ? ST_OUT : ST_SC_GO;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            have_r       <= 1'b0;
            len_sum_r    <= '0;
            slot_r       <= '0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          for (int k = 0; k < 3; k++) begin
            cur_r[k] <= in_tdata[CW*k +: CW];
          end
          cur_t_r    <= in_tdata[CW*3 +: CW];
          end_r      <= in_tlast || (slot_nxt == qtpl_pkg::SLOT_W'(qtpl_pkg::MAX_RECORDS));
          end_mode_r <= 1'b0;
          num_r      <= '0;
          sq_idx_r   <= '0;
          if (!in_tuser && !have_r) begin
            for (int k = 0; k < 3; k++) begin
              first_r[k] <= in_tdata[CW*k +: CW];
              prev_r[k]  <= in_tdata[CW*k +: CW];
            end
            first_t_r <= in_tdata[CW*3 +: CW];
            last_t_r  <= in_tdata[CW*3 +: CW];
          end
        end
      end
      ST_SQ: begin
        num_r    <= num_r + qtpl_pkg::RAD_W'(sq_val);
        sq_idx_r <= sq_idx_r + 1'b1;
        res_r    <= '0;
        bit_r    <= ROOT_BIT_INIT;
      end
      ST_ROOT: begin
        num_r <= num_nxt;
        res_r <= res_nxt;
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          if (end_mode_r) begin
            root_r <= res_nxt[qtpl_pkg::ROOT_W-1:0];
            sel_r  <= SEL_LEN;
          end else begin
            for (int k = 0; k < 3; k++) begin
              prev_r[k] <= cur_r[k];
            end
            last_t_r <= cur_t_r;
          end
        end
      end
      ST_CHK: begin
        end_mode_r <= 1'b1;
        num_r      <= '0;
        sq_idx_r   <= '0;
        // photon without any set record
        len_q_r    <= '0;
        end_q_r    <= '0;
        dur_q_r    <= '0;
      end
      ST_SC_WAIT: begin
        if (sc_stat.done) begin
          sel_r <= sel_r + 1'b1;
          case (sel_r)
            SEL_LEN: len_q_r <= sc_quot;
            SEL_END: end_q_r <= sc_quot;
            default: dur_q_r <= dt_neg ? (qtpl_pkg::OUT_W'(0) - sc_quot) : sc_quot;
          endcase
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_data_r <= {dur_q_r, end_q_r, len_q_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

[design/qtpl_scale.sv]
// bit-serial multiply by an extent and divide by 256 * 32767 with rounding
// shift-add multiply, restoring divide; depends on qtpl_pkg
module qtpl_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [qtpl_pkg::EXT_W-1:0]    mult_s,
  input  logic [qtpl_pkg::EXT_W-1:0]    mult_e,
  output qtpl_pkg::scale_stat_t         stat,
  output logic [qtpl_pkg::OUT_W-1:0]    quot
);

  localparam int CNT_W = $clog2(qtpl_pkg::DIV_W);

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_MUL  = 2'd1;
  localparam logic [1:0] SC_ADD  = 2'd2;
  localparam logic [1:0] SC_DIV  = 2'd3;

  logic [1:0]                      state_r;
  logic [CNT_W-1:0]                cnt_r;
  logic                            done_r;
  logic [qtpl_pkg::EXT_W-1:0]      mcand_r;
  logic [qtpl_pkg::EXT_W-1:0]      hi_r;
  logic [qtpl_pkg::EXT_W-1:0]      lo_r;
  logic [qtpl_pkg::DIV_W-1:0]      dq_r;
  logic [qtpl_pkg::REM_W-1:0]      rem_r;
  logic [qtpl_pkg::OUT_W-1:0]      q_r;

  logic [qtpl_pkg::EXT_W:0]        mul_sum;
  logic [qtpl_pkg::PROD_W-1:0]     rounded;
  logic [qtpl_pkg::REM_W:0]        trial;
  logic                            ge;
  logic [qtpl_pkg::REM_W-1:0]      rem_nxt;
  logic [qtpl_pkg::DIV_W-1:0]      dq_nxt;

  always_comb begin
    mul_sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);
    rounded = {hi_r, lo_r} + qtpl_pkg::SCALE_HALF;
    trial   = {rem_r, dq_r[qtpl_pkg::DIV_W-1]};
    ge      = (trial >= {1'b0, qtpl_pkg::SCALE_DIVISOR});
    rem_nxt = ge ? qtpl_pkg::REM_W'(trial - {1'b0, qtpl_pkg::SCALE_DIVISOR})
                 : trial[qtpl_pkg::REM_W-1:0];
    dq_nxt  = {dq_r[qtpl_pkg::DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        SC_IDLE: begin
          if (start) begin
            state_r <= SC_MUL;
            cnt_r   <= '0;
          end
        end
        SC_MUL: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(qtpl_pkg::EXT_W - 1)) begin
            state_r <= SC_ADD;
          end
        end
        SC_ADD: begin
          state_r <= SC_DIV;
          cnt_r   <= '0;
        end
        SC_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(qtpl_pkg::DIV_W - 1)) begin
            state_r <= SC_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= SC_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      SC_IDLE: begin
        if (start) begin
          mcand_r <= mult_e;
          hi_r    <= '0;
          lo_r    <= mult_s;
        end
      end
      SC_MUL: begin
        hi_r <= mul_sum[qtpl_pkg::EXT_W:1];
        lo_r <= {mul_sum[0], lo_r[qtpl_pkg::EXT_W-1:1]};
      end
      SC_ADD: begin
        dq_r  <= rounded[qtpl_pkg::PROD_W-1:qtpl_pkg::SCALE_SHIFT];
        rem_r <= '0;
      end
      SC_DIV: begin
        dq_r  <= dq_nxt;
        rem_r <= rem_nxt;
        if (cnt_r == CNT_W'(qtpl_pkg::DIV_W - 1)) begin
          // saturate when the quotient runs past the output width
          q_r <= (|dq_nxt[qtpl_pkg::DIV_W-1:qtpl_pkg::OUT_W]) ? '1
                                                           : dq_nxt[qtpl_pkg::OUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign stat.busy = (state_r != SC_IDLE);
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule
